// ===== sv/dlcd_pkg.sv =====
// Shared types, constants and the digit segment table for the segment LCD encoder.
// Depends on nothing; every other file of the block imports it.
package dlcd_pkg;

	localparam int unsigned NIBBLE_W = 4;

	// Largest value that each display mode can show.
	localparam logic [15:0] DEC_MAX  = 16'd9999;
	localparam logic [7:0]  PAIR_MAX = 8'd99;

	// Display modes.
	localparam logic OP_DECIMAL = 1'b0;
	localparam logic OP_TIME    = 1'b1;

	// Reciprocals for division by a constant; each is exact over the range it is used on.
	localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift 23, value below 10000
	localparam int unsigned SHIFT_1000 = 23;
	localparam logic [12:0] RECIP_100  = 13'd5243;  // shift 19, value below 10000
	localparam int unsigned SHIFT_100  = 19;
	localparam logic [12:0] RECIP_10   = 13'd6554;  // shift 16, value below 10000
	localparam int unsigned SHIFT_10   = 16;
	localparam logic [7:0]  RECIP_10_PAIR = 8'd205; // shift 11, value below 128
	localparam int unsigned SHIFT_10_PAIR = 11;

	// Fixed pattern shown on the eight pins when the input is out of range.
	localparam logic [NIBBLE_W-1:0] ERR_PATTERN [8] = '{
		4'hF, 4'h8, 4'h6, 4'h0, 4'h6, 4'h0, 4'h7, 4'h2
	};

	localparam logic [NIBBLE_W-1:0] DOT_MASK = 4'h1;

	typedef struct packed {
		logic        op;
		logic [15:0] value;
		logic [7:0]  left_pair;
		logic [7:0]  right_pair;
	} dlcd_req_t;

	typedef struct packed {
		logic [NIBBLE_W-1:0] digit1_pin_a;
		logic [NIBBLE_W-1:0] digit1_pin_b;
		logic [NIBBLE_W-1:0] digit2_pin_a;
		logic [NIBBLE_W-1:0] digit2_pin_b;
		logic [NIBBLE_W-1:0] digit3_pin_a;
		logic [NIBBLE_W-1:0] digit3_pin_b;
		logic [NIBBLE_W-1:0] digit4_pin_a;
		logic [NIBBLE_W-1:0] digit4_pin_b;
		logic                range_error;
	} dlcd_rsp_t;

	// Phase nibbles for one digit, first pin in the upper half. A blanked digit is
	// handled by the caller.
	function automatic logic [2*NIBBLE_W-1:0] seg_code(input logic [3:0] digit);
		logic [2*NIBBLE_W-1:0] code;
		case (digit)
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h7C;
			4'd3:    code = 8'h5E;
			4'd4:    code = 8'hC6;
			4'd5:    code = 8'hDA;
			4'd6:    code = 8'hFA;
			4'd7:    code = 8'h0E;
			4'd8:    code = 8'hFE;
			4'd9:    code = 8'hDE;
			default: code = 8'hBE;
		endcase
		return code;
	endfunction

endpackage

// ===== sv/dlcd_if.sv =====
// Valid/ready channels for display requests and encoded pin results.
// Depends on dlcd_pkg for the payload types.
interface dlcd_req_if import dlcd_pkg::*; ();
	logic      valid;
	logic      ready;
	dlcd_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface dlcd_rsp_if import dlcd_pkg::*; ();
	logic      valid;
	logic      ready;
	dlcd_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/dlcd_encode.sv =====
// Combinational encoder from one display request to the eight pin nibbles and error flag.
// Depends on dlcd_pkg for types, reciprocals, segment table and error pattern.
module dlcd_encode import dlcd_pkg::*; (
	input  dlcd_req_t req,
	output dlcd_rsp_t rsp
);

	logic [13:0] dec_v;
	logic [27:0] prod_1000;
	logic [26:0] prod_100;
	logic [26:0] prod_10;
	logic [3:0]  q_1000;
	logic [6:0]  q_100;
	logic [9:0]  q_10;
	logic [3:0]  dec_d [4];

	logic [6:0]  left_v;
	logic [6:0]  right_v;
	logic [14:0] prod_left;
	logic [14:0] prod_right;
	logic [3:0]  left_tens;
	logic [3:0]  right_tens;
	logic [3:0]  time_d [4];

	logic [3:0]  dig  [4];
	logic [3:0]  show;
	logic [7:0]  code [4];
	logic        err;

	// Decimal split: each quotient comes straight from the value; below the top digit,
	// each digit is a quotient (or the value) minus ten times the next coarser one.
	always_comb begin
		dec_v     = req.value[13:0];
		prod_1000 = dec_v * RECIP_1000;
		prod_100  = dec_v * RECIP_100;
		prod_10   = dec_v * RECIP_10;
		q_1000    = prod_1000[SHIFT_1000 +: 4];
		q_100     = prod_100[SHIFT_100 +: 7];
		q_10      = prod_10[SHIFT_10 +: 10];
		dec_d[0]  = q_1000;
		dec_d[1]  = 4'(q_100 - 7'd10 * {3'b000, q_1000});
		dec_d[2]  = 4'(q_10 - 10'd10 * {3'b000, q_100});
		dec_d[3]  = 4'(dec_v - 14'd10 * {4'b0000, q_10});
	end

	always_comb begin
		left_v     = req.left_pair[6:0];
		right_v    = req.right_pair[6:0];
		prod_left  = left_v * RECIP_10_PAIR;
		prod_right = right_v * RECIP_10_PAIR;
		left_tens  = prod_left[SHIFT_10_PAIR +: 4];
		right_tens = prod_right[SHIFT_10_PAIR +: 4];
		time_d[0]  = left_tens;
		time_d[1]  = 4'(left_v - 7'd10 * {3'b000, left_tens});
		time_d[2]  = right_tens;
		time_d[3]  = 4'(right_v - 7'd10 * {3'b000, right_tens});
	end

	always_comb begin
		if (req.op == OP_TIME) begin
			err = (req.left_pair > PAIR_MAX) || (req.right_pair > PAIR_MAX);
			for (int i = 0; i < 4; i++) begin
				dig[i] = time_d[i];
			end
		end else begin
			err = req.value > DEC_MAX;
			for (int i = 0; i < 4; i++) begin
				dig[i] = dec_d[i];
			end
		end

		// Leading zeros go dark; in time mode the second field is always lit.
		show[0] = dig[0] != 4'd0;
		show[1] = show[0] || (dig[1] != 4'd0);
		show[2] = show[1] || (dig[2] != 4'd0) || (req.op == OP_TIME);
		show[3] = 1'b1;

		for (int i = 0; i < 4; i++) begin
			code[i] = show[i] ? seg_code(dig[i]) : 8'h00;
		end

		if (err) begin
			rsp.digit1_pin_a = ERR_PATTERN[0];
			rsp.digit1_pin_b = ERR_PATTERN[1];
			rsp.digit2_pin_a = ERR_PATTERN[2];
			rsp.digit2_pin_b = ERR_PATTERN[3];
			rsp.digit3_pin_a = ERR_PATTERN[4];
			rsp.digit3_pin_b = ERR_PATTERN[5];
			rsp.digit4_pin_a = ERR_PATTERN[6];
			rsp.digit4_pin_b = ERR_PATTERN[7];
			rsp.range_error  = 1'b1;
		end else begin
			rsp.digit1_pin_a = code[0][7:4];
			rsp.digit1_pin_b = code[0][3:0];
			rsp.digit2_pin_a = code[1][7:4];
			rsp.digit2_pin_b = code[1][3:0];
			rsp.digit3_pin_a = code[2][7:4];
			rsp.digit3_pin_b = code[2][3:0];
			rsp.digit4_pin_a = code[3][7:4];
			rsp.digit4_pin_b = (req.op == OP_TIME) ? (code[3][3:0] | DOT_MASK) : code[3][3:0];
			rsp.range_error  = 1'b0;
		end
	end

endmodule

// ===== sv/decimal_to_lcd_segment_encoder_core.sv =====
// Top level of the segment LCD encoder: input register, encoder, result register.
// Depends on dlcd_pkg, dlcd_req_if, dlcd_rsp_if and dlcd_encode.

// The block accepts one display request per clock cycle unless the result side stalls.
// A request is held in the input register, passes through the encoder logic and
// lands in the result register. Each register advances on its own, so a stalled
// result still lets one more request in, and the block runs at full rate whenever
// the result side takes a beat every cycle. There is no configuration and no state
// that lasts beyond one request.
module decimal_to_lcd_segment_encoder_core import dlcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	dlcd_req_if.sink      request,
	dlcd_rsp_if.source    result
);

	logic      valid_s1;
	dlcd_req_t req_s1;
	logic      valid_s2;
	dlcd_rsp_t rsp_s2;
	dlcd_rsp_t enc_rsp;
	logic      load_s2;

	dlcd_encode u_encode (
		.req (req_s1),
		.rsp (enc_rsp)
	);

	assign load_s2       = !valid_s2 || result.ready;
	assign request.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (request.ready) begin
				valid_s1 <= request.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready) begin
			req_s1 <= request.payload;
		end
		if (load_s2) begin
			rsp_s2 <= enc_rsp;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = rsp_s2;

endmodule
